/* rtl/page_bump_allocator_core_macros.svh */
// Assertion macros used by the checker file.
`ifndef PAGE_BUMP_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_BUMP_ALLOCATOR_CORE_MACROS_SVH

// Checked only while out of reset.
`define PB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/pbump_pkg.sv */
// Shared constants and types of the page bump allocator.
`default_nettype none
package pbump_pkg;

    localparam int NUM_PAGES     = 64;
    localparam int PAGE_W        = 6;
    localparam int LINK_W        = 7;
    localparam int SIZE_W        = 13;
    localparam int HEADER_BYTES  = 8;
    localparam int PAYLOAD_MAX   = 4096;
    localparam int PAYLOAD_RESET = 1024;

    localparam logic [LINK_W-1:0] NIL_PAGE = LINK_W'(NUM_PAGES);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_PAGE   = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [0:0] REG_PAGE_PAYLOAD = 1'b0;

    typedef struct packed {
        logic [SIZE_W-1:0] bump;
        logic [SIZE_W-1:0] live;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] next;
    } t_page_ent;

endpackage
`default_nettype wire

/* rtl/pbump_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none
module pbump_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* rtl/page_bump_allocator_core.sv */
// Page bump allocator: top level with sequencer and page/FIFO memories.
`default_nettype none
// Use: one request beat on the input channel (i_in_valid / o_in_stall)
// gives exactly one result beat on the output channel (o_out_valid /
// i_out_stall). Allocate bumps the newest active page, opening a released
// or never-used page when it is full or no page is active; free drops the
// page's live count and unlinks and queues the page when it reaches zero.
// Steps: allocate into the current page reads and rewrites the tail entry;
// allocate opening a page takes up to tail read, FIFO read, new entry and
// tail link; free takes entry read, then prev and next relink as needed;
// error results write no memory.
// Each request is a read/modify/write sequence on one page memory port
// pair, so one request is worked at a time; a new request is taken as soon
// as the previous result sits in the output register.
// Reset (synchronous, i_rst_n low): list empty, no page active, FIFO empty,
// page size register 1024. No memory sweep is needed; entries are always
// written when a page is opened before they are read.
// While the receiver stalls, the result beat holds; the block may take one
// more request and parks its result until the output register frees.
// page_payload_bytes sits at APB address 0; values above 4096 act as 4096.
module page_bump_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_action,
    input  wire logic [12:0] i_request_size,
    input  wire logic [5:0]  i_block_page,
    input  wire logic [12:0] i_block_offset,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [5:0]       o_granted_page,
    output logic [12:0]      o_granted_offset,
    output logic             o_page_released,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int PW = pbump_pkg::PAGE_W;
    localparam int LW = pbump_pkg::LINK_W;
    localparam int SW = pbump_pkg::SIZE_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ARD  = 4'd1;  // tail entry read back
    localparam logic [3:0] S_FIFO = 4'd2;  // released page index read back
    localparam logic [3:0] S_NEW  = 4'd3;  // write fresh entry
    localparam logic [3:0] S_LINK = 4'd4;  // old tail next -> new page
    localparam logic [3:0] S_FRD  = 4'd5;  // freed page entry read back
    localparam logic [3:0] S_PRD  = 4'd6;  // prev entry read back
    localparam logic [3:0] S_NRD  = 4'd7;  // next entry read back
    localparam logic [3:0] S_OUT  = 4'd8;  // result waits for output reg

    // control state
    logic [3:0]    r_state, n_state;
    logic [63:0]   r_active, n_active;
    logic [LW-1:0] r_head, n_head, r_tail, n_tail;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [LW-1:0] r_rcnt, n_rcnt, r_fresh, n_fresh;
    logic          r_ovalid, n_ovalid;
    logic [SW-1:0] r_cfg;

    // datapath state
    logic          r_act, n_act;
    logic [SW-1:0] r_size, n_size, r_off, n_off;
    logic [PW-1:0] r_pg, n_pg, r_np, n_np;
    logic [LW-1:0] r_p, n_p, r_n, n_n;
    pbump_pkg::t_page_ent r_ent, n_ent;
    logic [1:0]    r_res_status, n_res_status, r_ostatus, n_ostatus;
    logic [PW-1:0] r_res_page, n_res_page, r_opage, n_opage;
    logic [SW-1:0] r_res_off, n_res_off, r_ooff, n_ooff;
    logic          r_res_rel, n_res_rel, r_orel, n_orel;

    // memories
    logic                 pg_we;
    logic [PW-1:0]        pg_waddr, pg_raddr;
    pbump_pkg::t_page_ent pg_wdata, pg_rdata;
    logic                 ff_we;
    logic [PW-1:0]        ff_waddr, ff_wdata, ff_rdata;

    // arithmetic
    logic          cfg_we, in_acc, out_free;
    logic [SW-1:0] pay, cap;
    logic [SW:0]   reals, off_end;
    logic [SW+1:0] bump_end;
    logic [SW-1:0] new_live;
    logic          need_page, bad_free;

    assign cfg_we = psel && penable && pwrite && (paddr == pbump_pkg::REG_PAGE_PAYLOAD);
    assign pready = 1'b1;
    assign prdata = (paddr == pbump_pkg::REG_PAGE_PAYLOAD) ? {19'd0, r_cfg} : 32'd0;

    assign pay = (r_cfg > SW'(pbump_pkg::PAYLOAD_MAX)) ? SW'(pbump_pkg::PAYLOAD_MAX) : r_cfg;
    assign cap = pay + SW'(pbump_pkg::HEADER_BYTES);

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovalid || !i_out_stall;

    // request size plus header, from the accept-time or latched size
    assign reals    = (r_state == S_IDLE)
                      ? ({1'b0, i_request_size} + (SW+1)'(pbump_pkg::HEADER_BYTES))
                      : ({1'b0, r_size} + (SW+1)'(pbump_pkg::HEADER_BYTES));
    assign bump_end = (SW+2)'(pg_rdata.bump) + (SW+2)'(reals);
    assign need_page = bump_end > (SW+2)'(cap);
    assign off_end  = {1'b0, r_off} + {1'b0, r_size};
    assign bad_free = (r_off < SW'(pbump_pkg::HEADER_BYTES)) ||
                      (off_end > {1'b0, pg_rdata.bump}) ||
                      ({1'b0, pg_rdata.live} < reals);
    assign new_live = pg_rdata.live - SW'(reals);

    pbump_ram #(
        .WIDTH ($bits(pbump_pkg::t_page_ent)),
        .DEPTH (pbump_pkg::NUM_PAGES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_raddr (pg_raddr),
        .o_rdata (pg_rdata)
    );

    // released-page queue; always reads at the head
    pbump_ram #(
        .WIDTH (PW),
        .DEPTH (pbump_pkg::NUM_PAGES)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (ff_we),
        .i_waddr (ff_waddr),
        .i_wdata (ff_wdata),
        .i_raddr (r_rptr),
        .o_rdata (ff_rdata)
    );

    always_comb begin
        n_state = r_state;   n_active = r_active; n_head = r_head;   n_tail = r_tail;
        n_rptr = r_rptr;     n_rcnt = r_rcnt;     n_fresh = r_fresh; n_ovalid = r_ovalid;
        n_act = r_act;       n_size = r_size;     n_off = r_off;     n_pg = r_pg;
        n_np = r_np;         n_p = r_p;           n_n = r_n;         n_ent = r_ent;
        n_res_status = r_res_status; n_res_page = r_res_page;
        n_res_off = r_res_off;       n_res_rel = r_res_rel;
        n_ostatus = r_ostatus; n_opage = r_opage; n_ooff = r_ooff; n_orel = r_orel;
        pg_we = 1'b0; pg_waddr = r_pg; pg_wdata = pg_rdata; pg_raddr = r_pg;
        ff_we = 1'b0; ff_waddr = r_rptr + r_rcnt[PW-1:0]; ff_wdata = r_pg;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                pg_raddr = (i_action == pbump_pkg::ACT_FREE) ? i_block_page : r_tail[PW-1:0];
                if (in_acc) begin
                    n_act = i_action; n_size = i_request_size;
                    n_off = i_block_offset; n_pg = i_block_page;
                    n_res_status = pbump_pkg::ST_OK; n_res_page = '0;
                    n_res_off = '0; n_res_rel = 1'b0;
                    if (i_action == pbump_pkg::ACT_FREE) begin
                        if (!r_active[i_block_page]) begin
                            n_res_status = pbump_pkg::ST_BAD_FREE;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_FRD;
                        end
                    end else if (reals > {1'b0, cap}) begin
                        n_res_status = pbump_pkg::ST_TOO_LARGE;
                        n_state = S_OUT;
                    end else if (r_tail == pbump_pkg::NIL_PAGE) begin
                        // no active page: open one
                        if (r_rcnt != '0) begin
                            n_state = S_FIFO;
                        end else if (!r_fresh[LW-1]) begin
                            n_np = r_fresh[PW-1:0]; n_fresh = r_fresh + 1'b1;
                            n_state = S_NEW;
                        end else begin
                            n_res_status = pbump_pkg::ST_NO_PAGE;
                            n_state = S_OUT;
                        end
                    end else begin
                        n_state = S_ARD;
                    end
                end
            end
            S_ARD: begin
                n_ent = pg_rdata;
                if (!need_page) begin
                    pg_we = 1'b1; pg_waddr = r_tail[PW-1:0];
                    pg_wdata.bump = SW'(bump_end);
                    pg_wdata.live = pg_rdata.live + SW'(reals);
                    n_res_page = r_tail[PW-1:0];
                    n_res_off  = pg_rdata.bump + SW'(pbump_pkg::HEADER_BYTES);
                    n_state = S_OUT;
                end else if (r_rcnt != '0) begin
                    n_state = S_FIFO;
                end else if (!r_fresh[LW-1]) begin
                    n_np = r_fresh[PW-1:0]; n_fresh = r_fresh + 1'b1;
                    n_state = S_NEW;
                end else begin
                    n_res_status = pbump_pkg::ST_NO_PAGE;
                    n_state = S_OUT;
                end
            end
            S_FIFO: begin
                n_np = ff_rdata;
                n_rptr = r_rptr + 1'b1;
                n_rcnt = r_rcnt - 1'b1;
                n_state = S_NEW;
            end
            S_NEW: begin
                pg_we = 1'b1; pg_waddr = r_np;
                pg_wdata.bump = SW'(reals);
                pg_wdata.live = SW'(reals);
                pg_wdata.prev = r_tail;
                pg_wdata.next = pbump_pkg::NIL_PAGE;
                n_active[r_np] = 1'b1;
                n_res_page = r_np;
                n_res_off  = SW'(pbump_pkg::HEADER_BYTES);
                if (r_tail == pbump_pkg::NIL_PAGE) begin
                    n_head = {1'b0, r_np}; n_tail = {1'b0, r_np};
                    n_state = S_OUT;
                end else begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                pg_we = 1'b1; pg_waddr = r_tail[PW-1:0];
                pg_wdata = r_ent;
                pg_wdata.next = {1'b0, r_np};
                n_tail = {1'b0, r_np};
                n_state = S_OUT;
            end
            S_FRD: begin
                if (bad_free) begin
                    n_res_status = pbump_pkg::ST_BAD_FREE;
                    n_state = S_OUT;
                end else begin
                    pg_we = 1'b1; pg_waddr = r_pg;
                    pg_wdata.live = new_live;
                    if (new_live != '0) begin
                        n_state = S_OUT;
                    end else begin
                        // page empty: queue it and unlink
                        n_active[r_pg] = 1'b0;
                        ff_we = 1'b1;
                        n_rcnt = r_rcnt + 1'b1;
                        n_res_rel = 1'b1;
                        n_p = pg_rdata.prev; n_n = pg_rdata.next;
                        if (pg_rdata.prev != pbump_pkg::NIL_PAGE) begin
                            pg_raddr = pg_rdata.prev[PW-1:0];
                            n_state = S_PRD;
                        end else begin
                            n_head = pg_rdata.next;
                            if (pg_rdata.next != pbump_pkg::NIL_PAGE) begin
                                pg_raddr = pg_rdata.next[PW-1:0];
                                n_state = S_NRD;
                            end else begin
                                n_tail = pbump_pkg::NIL_PAGE;
                                n_state = S_OUT;
                            end
                        end
                    end
                end
            end
            S_PRD: begin
                pg_we = 1'b1; pg_waddr = r_p[PW-1:0];
                pg_wdata.next = r_n;
                if (r_n != pbump_pkg::NIL_PAGE) begin
                    pg_raddr = r_n[PW-1:0];
                    n_state = S_NRD;
                end else begin
                    n_tail = r_p;
                    n_state = S_OUT;
                end
            end
            S_NRD: begin
                pg_we = 1'b1; pg_waddr = r_n[PW-1:0];
                pg_wdata.prev = r_p;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ostatus = r_res_status; n_opage = r_res_page;
                    n_ooff = r_res_off;       n_orel = r_res_rel;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_head   <= pbump_pkg::NIL_PAGE;
            r_tail   <= pbump_pkg::NIL_PAGE;
            r_rptr   <= '0;
            r_rcnt   <= '0;
            r_fresh  <= '0;
            r_ovalid <= 1'b0;
            r_cfg    <= SW'(pbump_pkg::PAYLOAD_RESET);
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_rptr   <= n_rptr;
            r_rcnt   <= n_rcnt;
            r_fresh  <= n_fresh;
            r_ovalid <= n_ovalid;
            if (cfg_we) begin
                r_cfg <= pwdata[SW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;   r_size <= n_size; r_off <= n_off; r_pg <= n_pg;
        r_np <= n_np;     r_p <= n_p;       r_n <= n_n;     r_ent <= n_ent;
        r_res_status <= n_res_status; r_res_page <= n_res_page;
        r_res_off <= n_res_off;       r_res_rel <= n_res_rel;
        r_ostatus <= n_ostatus; r_opage <= n_opage; r_ooff <= n_ooff; r_orel <= n_orel;
    end

    assign o_out_valid      = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_granted_page   = r_opage;
    assign o_granted_offset = r_ooff;
    assign o_page_released  = r_orel;

    // the latched action is kept for debug visibility on the head entry
    logic unused_dbg;
    assign unused_dbg = r_act ^ r_head[0];
endmodule
`default_nettype wire

/* rtl/pbump_chk.sv */
// Port-level checker for the page bump allocator, with its bind.
`default_nettype none
`include "page_bump_allocator_core_macros.svh"
module pbump_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_action,
    input wire logic [12:0] i_request_size,
    input wire logic [5:0]  i_block_page,
    input wire logic [12:0] i_block_offset,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_status,
    input wire logic [5:0]  o_granted_page,
    input wire logic [12:0] o_granted_offset,
    input wire logic        o_page_released,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [0:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);
    `PB_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_out_valid, "result beat right after reset")
    `PB_ASSERT(a_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_granted_offset), "stalled result changed")
    `PB_ASSERT(a_err_zero, o_out_valid && (o_status != pbump_pkg::ST_OK) |-> (o_granted_page == '0) && (o_granted_offset == '0) && !o_page_released, "error beat carries grant")
    `PB_ASSERT(a_rel_free, o_out_valid && o_page_released |-> (o_status == pbump_pkg::ST_OK) && (o_granted_offset == '0), "release flagged on non-free beat")
    `PB_ASSERT(a_grant_hdr, o_out_valid && (o_status == pbump_pkg::ST_OK) && !o_page_released && (o_granted_offset != '0) |-> o_granted_offset >= 13'(pbump_pkg::HEADER_BYTES), "grant offset inside header")
endmodule

bind page_bump_allocator_core pbump_chk u_pbump_chk (.*);
`default_nettype wire
